@@ design/abhl_pkg.sv @@
// ----------------------------------------------------------------------------
// abhl_pkg
// Shared types and constants for the archive block header lister.
// ----------------------------------------------------------------------------
package abhl_pkg;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] END_CLEAN  = 2'd0;
  localparam logic [1:0] END_TRUNC  = 2'd1;
  localparam logic [1:0] END_NOMARK = 2'd2;

  localparam logic [7:0]  TYPE_FILE = 8'h74;
  localparam int          FLAG_ADD_BIT = 15;
  localparam logic [11:0] YEAR_BASE = 12'd1980;
  localparam int          QDEPTH = 4;
  localparam int          QAW = $clog2(QDEPTH);

  // Classified request passed from the parser to the result formatter.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] packed_size;
    logic [31:0] unpacked_size;
    logic [15:0] dos_date;
    logic [15:0] dos_time;
    logic [7:0]  name_char;
    logic        last_of_entry;
    logic [1:0]  end_status;
  } req_t;

  function automatic logic [7:0] marker_byte(input logic [2:0] i);
    case (i)
      3'd0:    marker_byte = 8'h52;
      3'd1:    marker_byte = 8'h61;
      3'd2:    marker_byte = 8'h72;
      3'd3:    marker_byte = 8'h21;
      3'd4:    marker_byte = 8'h1a;
      3'd5:    marker_byte = 8'h07;
      default: marker_byte = 8'h00;
    endcase
  endfunction

endpackage

@@ design/abhl_front.sv @@
// ----------------------------------------------------------------------------
// abhl_front
// Byte parser: marker search, header capture, skipping; issues requests.
// ----------------------------------------------------------------------------
module abhl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_vld,
  input  logic [7:0]     byte_dat,
  input  logic           byte_end,
  output logic           req0_vld,
  output abhl_pkg::req_t req0,
  output logic           req1_vld,
  output abhl_pkg::req_t req1
);
  import abhl_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH, PH_HDR, PH_ADD, PH_FILE, PH_NAME, PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  mm_r, mm_nxt;
  logic [5:0]  bi_r, bi_nxt;
  logic [7:0]  btype_r, btype_nxt;
  logic [15:0] bflags_r, bflags_nxt;
  logic [15:0] bsize_r, bsize_nxt;
  logic [15:0] extra_r, extra_nxt;
  logic [31:0] pk_r, pk_nxt;
  logic [31:0] up_r, up_nxt;
  logic [15:0] tm_r, tm_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [15:0] nleft_r, nleft_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [32:0] skip_amt;
  logic        skip_go;
  logic [16:0] used;
  logic [15:0] nleft_dec;
  logic        hit;
  req_t        r0, r1;
  logic        v0, v1;

  always_comb begin
    phase_nxt = phase_r; mm_nxt = mm_r; bi_nxt = bi_r; btype_nxt = btype_r;
    bflags_nxt = bflags_r; bsize_nxt = bsize_r; extra_nxt = extra_r;
    pk_nxt = pk_r; up_nxt = up_r; tm_nxt = tm_r; dt_nxt = dt_r;
    nlen_nxt = nlen_r; nleft_nxt = nleft_r; skip_nxt = skip_r;
    skip_amt = '0; skip_go = 1'b0;
    used = 17'd32 + {1'b0, nlen_r};
    nleft_dec = nleft_r - 16'd1;
    hit = (byte_dat == marker_byte(mm_r));
    r0 = '0; r1 = '0; v0 = 1'b0; v1 = 1'b0;
    if (byte_vld) begin
      case (phase_r)
        PH_SEARCH: begin
          if (hit) mm_nxt = mm_r + 3'd1;
          else mm_nxt = (byte_dat == 8'h52) ? 3'd1 : 3'd0;
          if (hit && mm_r == 3'd6) begin
            mm_nxt = '0; phase_nxt = PH_HDR; bi_nxt = '0;
          end
        end
        PH_HDR: begin
          case (bi_r)
            6'd2: btype_nxt = byte_dat;
            6'd3: bflags_nxt[7:0] = byte_dat;
            6'd4: bflags_nxt[15:8] = byte_dat;
            6'd5: bsize_nxt[7:0] = byte_dat;
            6'd6: bsize_nxt[15:8] = byte_dat;
            default: ;
          endcase
          bi_nxt = bi_r + 6'd1;
          if (bi_r == 6'd6) begin
            if (btype_nxt == TYPE_FILE) phase_nxt = PH_FILE;
            else if (bflags_nxt[FLAG_ADD_BIT]) phase_nxt = PH_ADD;
            else begin
              skip_go = 1'b1;
              skip_amt = (bsize_nxt > 16'd7) ? {17'd0, bsize_nxt - 16'd7} : '0;
            end
          end
        end
        PH_ADD: begin
          if (bi_r[0]) extra_nxt[7:0] = byte_dat;
          else extra_nxt[15:8] = byte_dat;
          bi_nxt = bi_r + 6'd1;
          if (bi_r == 6'd8) begin
            skip_go = 1'b1;
            skip_amt = ((bsize_r > 16'd9) ? {17'd0, bsize_r - 16'd9} : 33'd0)
                       + {17'd0, extra_nxt};
          end
        end
        PH_FILE: begin
          case (bi_r)
            6'd7:  pk_nxt[7:0]   = byte_dat;
            6'd8:  pk_nxt[15:8]  = byte_dat;
            6'd9:  pk_nxt[23:16] = byte_dat;
            6'd10: pk_nxt[31:24] = byte_dat;
            6'd11: up_nxt[7:0]   = byte_dat;
            6'd12: up_nxt[15:8]  = byte_dat;
            6'd13: up_nxt[23:16] = byte_dat;
            6'd14: up_nxt[31:24] = byte_dat;
            6'd20: tm_nxt[7:0]   = byte_dat;
            6'd21: tm_nxt[15:8]  = byte_dat;
            6'd22: dt_nxt[7:0]   = byte_dat;
            6'd23: dt_nxt[15:8]  = byte_dat;
            6'd26: nlen_nxt[7:0] = byte_dat;
            6'd27: nlen_nxt[15:8] = byte_dat;
            default: ;
          endcase
          bi_nxt = bi_r + 6'd1;
          if (bi_r == 6'd31) begin
            nleft_nxt = nlen_r;
            v0 = 1'b1;
            r0.kind = KIND_ENTRY; r0.packed_size = pk_r; r0.unpacked_size = up_r;
            r0.dos_date = dt_r; r0.dos_time = tm_r;
            r0.last_of_entry = (nlen_r == 16'd0);
            if (nlen_r == 16'd0) begin
              skip_go = 1'b1;
              skip_amt = ((bsize_r > 16'd32) ? {17'd0, bsize_r - 16'd32} : 33'd0)
                         + {1'b0, pk_r};
            end else phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          v0 = 1'b1;
          r0.kind = KIND_NAME;
          r0.name_char = (byte_dat >= 8'h20 && byte_dat <= 8'h7e) ? byte_dat : 8'h3f;
          r0.last_of_entry = (nleft_dec == 16'd0);
          nleft_nxt = nleft_dec;
          if (nleft_dec == 16'd0) begin
            skip_go = 1'b1;
            skip_amt = (({1'b0, bsize_r} > used) ?
                        {16'd0, {1'b0, bsize_r} - used} : 33'd0) + {1'b0, pk_r};
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_nxt == '0) begin
            phase_nxt = PH_HDR; bi_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_SEARCH; mm_nxt = '0;
        end
      endcase
      if (skip_go) begin
        skip_nxt = skip_amt; bi_nxt = '0;
        phase_nxt = (skip_amt == '0) ? PH_HDR : PH_SKIP;
      end
      if (byte_end) begin
        r1.kind = KIND_END;
        if (phase_nxt == PH_SEARCH) r1.end_status = END_NOMARK;
        else if ((phase_nxt == PH_HDR && bi_nxt == '0) || phase_nxt == PH_SKIP)
          r1.end_status = END_CLEAN;
        else r1.end_status = END_TRUNC;
        if (v0) v1 = 1'b1;
        else begin
          v0 = 1'b1; r0 = r1;
        end
        phase_nxt = PH_SEARCH; mm_nxt = '0; bi_nxt = '0; btype_nxt = '0;
        bflags_nxt = '0; bsize_nxt = '0; extra_nxt = '0; pk_nxt = '0;
        up_nxt = '0; tm_nxt = '0; dt_nxt = '0; nlen_nxt = '0;
        nleft_nxt = '0; skip_nxt = '0;
      end
    end
  end

  assign req0_vld = v0;
  assign req0 = r0;
  assign req1_vld = v1;
  assign req1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH; mm_r <= '0; bi_r <= '0; btype_r <= '0;
      bflags_r <= '0; bsize_r <= '0; extra_r <= '0; pk_r <= '0; up_r <= '0;
      tm_r <= '0; dt_r <= '0; nlen_r <= '0; nleft_r <= '0; skip_r <= '0;
    end else begin
      phase_r <= phase_nxt; mm_r <= mm_nxt; bi_r <= bi_nxt; btype_r <= btype_nxt;
      bflags_r <= bflags_nxt; bsize_r <= bsize_nxt; extra_r <= extra_nxt;
      pk_r <= pk_nxt; up_r <= up_nxt; tm_r <= tm_nxt; dt_r <= dt_nxt;
      nlen_r <= nlen_nxt; nleft_r <= nleft_nxt; skip_r <= skip_nxt;
    end
  end

endmodule

@@ design/abhl_queue.sv @@
// ----------------------------------------------------------------------------
// abhl_queue
// Request queue; takes up to two requests per cycle, gives one.
// ----------------------------------------------------------------------------
module abhl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr0,
  input  abhl_pkg::req_t wd0,
  input  logic           wr1,
  input  abhl_pkg::req_t wd1,
  output logic           room2,
  output logic           rd_vld,
  output abhl_pkg::req_t rd_dat,
  input  logic           rd_take
);
  import abhl_pkg::*;

  req_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic [QAW-1:0] wp1;

  assign wp1 = wp_r + QAW'(1);
  assign room2 = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign rd_vld = (cnt_r != '0);
  assign rd_dat = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + QAW'(wr0) + QAW'(wr1);
    rp_nxt = rp_r + QAW'(rd_take);
    cnt_nxt = cnt_r + (QAW+1)'(wr0) + (QAW+1)'(wr1) - (QAW+1)'(rd_take);
  end

  always_ff @(posedge clk) begin
    if (wr0) mem_r[wp_r] <= wd0;
    if (wr1) mem_r[wp1] <= wd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/abhl_back.sv @@
// ----------------------------------------------------------------------------
// abhl_back
// Result formatter: decodes DOS date/time and drives the output register.
// ----------------------------------------------------------------------------
module abhl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  abhl_pkg::req_t q_dat,
  output logic           q_take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_kind,
  output logic [31:0]    out_packed_size,
  output logic [31:0]    out_unpacked_size,
  output logic [11:0]    out_year,
  output logic [3:0]     out_month,
  output logic [4:0]     out_day,
  output logic [4:0]     out_hour,
  output logic [5:0]     out_minute,
  output logic [5:0]     out_second,
  output logic [7:0]     out_name_char,
  output logic           out_last_of_entry,
  output logic [1:0]     out_end_status
);
  import abhl_pkg::*;

  logic  vld_r;
  req_t  d_r;
  logic  ent;

  assign q_take = q_vld && (!vld_r || !out_stall);
  assign ent = (d_r.kind == KIND_ENTRY);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (!vld_r || !out_stall) vld_r <= q_vld;
  end

  always_ff @(posedge clk) begin
    if (q_take) d_r <= q_dat;
  end

  assign out_valid = vld_r;
  assign out_kind = d_r.kind;
  assign out_packed_size = d_r.packed_size;
  assign out_unpacked_size = d_r.unpacked_size;
  assign out_year = ent ? (YEAR_BASE + {5'd0, d_r.dos_date[15:9]}) : '0;
  assign out_month = d_r.dos_date[8:5];
  assign out_day = d_r.dos_date[4:0];
  assign out_hour = d_r.dos_time[15:11];
  assign out_minute = d_r.dos_time[10:5];
  assign out_second = {d_r.dos_time[4:0], 1'b0};
  assign out_name_char = d_r.name_char;
  assign out_last_of_entry = d_r.last_of_entry;
  assign out_end_status = d_r.end_status;

endmodule

@@ design/archive_block_header_lister.sv @@
// ----------------------------------------------------------------------------
// archive_block_header_lister
// Lists file entries of an archive byte stream.
// ----------------------------------------------------------------------------
// Input: one archive byte per request (in_data_byte, in_stream_end marks
// the last byte). Output: entry records (sizes, DOS date/time), one request
// per name byte, and an end record with status after the final byte.
// Throughput: one byte per cycle; a byte causes at most two results
// (name or entry, then end record). Both go into a four-deep request queue
// between the parser and the output register; the parser stalls input only
// when fewer than two queue slots are free.
// Each result is written to the queue and then to the output register; a
// second result from the same byte follows behind the first.
// Output stall holds the output register; the queue absorbs bursts.
// Reset clears parser state and empties the queue; the next byte starts a
// fresh marker search. The end record also returns the parser to reset.
// ----------------------------------------------------------------------------
module archive_block_header_lister (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_packed_size,
  output logic [31:0] out_unpacked_size,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [7:0]  out_name_char,
  output logic        out_last_of_entry,
  output logic [1:0]  out_end_status
);
  import abhl_pkg::*;

  logic room2, acc, v0, v1, qv, qt;
  req_t r0, r1, qd;

  assign in_stall = !room2;
  assign acc = in_valid && room2;

  abhl_front u_front (
    .clk, .rst_n, .byte_vld(acc), .byte_dat(in_data_byte),
    .byte_end(in_stream_end), .req0_vld(v0), .req0(r0), .req1_vld(v1), .req1(r1)
  );

  abhl_queue u_queue (
    .clk, .rst_n, .wr0(v0), .wd0(r0), .wr1(v1), .wd1(r1),
    .room2, .rd_vld(qv), .rd_dat(qd), .rd_take(qt)
  );

  abhl_back u_back (
    .clk, .rst_n, .q_vld(qv), .q_dat(qd), .q_take(qt),
    .out_valid, .out_stall, .out_kind, .out_packed_size, .out_unpacked_size,
    .out_year, .out_month, .out_day, .out_hour, .out_minute, .out_second,
    .out_name_char, .out_last_of_entry, .out_end_status
  );

endmodule

@@ design/abhl_checker.sv @@
// ----------------------------------------------------------------------------
// abhl_port_checks
// Port-level checks for the archive block header lister.
// ----------------------------------------------------------------------------
module abhl_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_end_status,
  input logic        out_last_of_entry,
  input logic [7:0]  out_name_char
);
  import abhl_pkg::*;

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("output changed under stall");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_ENTRY || out_kind == KIND_NAME ||
                  out_kind == KIND_END)
    else $error("bad kind");

  a_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NAME |->
      out_name_char >= 8'h20 && out_name_char <= 8'h7e)
    else $error("unfiltered name byte");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> !out_last_of_entry &&
      out_end_status != 2'd3)
    else $error("bad end record");

endmodule

bind archive_block_header_lister abhl_port_checks u_abhl_port_checks (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_kind,
  .out_end_status, .out_last_of_entry, .out_name_char
);

@@ bench/abhl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhl_checker
// Watches both channels of the archive block header lister, predicts the
// entry, name and end records for every accepted byte and compares them
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module abhl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_packed_size,
  input  logic [31:0] out_unpacked_size,
  input  logic [11:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  input  logic [4:0]  out_hour,
  input  logic [5:0]  out_minute,
  input  logic [5:0]  out_second,
  input  logic [7:0]  out_name_char,
  input  logic        out_last_of_entry,
  input  logic [1:0]  out_end_status,
  output int          fail_count,
  output int          records_waiting,
  output int          records_seen
);
  import abhl_pkg::*;

  typedef enum logic [2:0] {
    P_SEARCH, P_HDR, P_ADD, P_FILE, P_NAME, P_SKIP
  } parse_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] pk;
    logic [31:0] unp;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [7:0]  name_char;
    logic        last;
    logic [1:0]  status;
  } record_t;

  record_t     listing_q[$];
  parse_t      ph;
  logic [2:0]  matched;
  logic [5:0]  idx;
  logic [7:0]  btype;
  logic [15:0] bflags, bsize, addsz, ftime, fdate, nlen, nleft;
  logic [31:0] fpk, funp;
  logic [32:0] skip;

  task automatic clear_parser();
    ph = P_SEARCH; matched = 0; idx = 0; btype = 0; bflags = 0; bsize = 0;
    addsz = 0; fpk = 0; funp = 0; ftime = 0; fdate = 0; nlen = 0; nleft = 0;
    skip = 0;
  endtask

  task automatic start_skip(input logic [33:0] n);
    skip = n[32:0];
    idx = 0;
    ph = (skip == 0) ? P_HDR : P_SKIP;
  endtask

  task automatic skip_file_body();
    logic [16:0] used;
    logic [33:0] rest;
    used = 17'd32 + {1'b0, nlen};
    rest = ({1'b0, bsize} > used) ? 34'({1'b0, bsize} - used) : 34'd0;
    start_skip(rest + {2'b00, fpk});
  endtask

  task automatic list_byte(input logic [7:0] b, input logic fin);
    record_t r;
    r = '{default: 0};
    case (ph)
      P_SEARCH: begin
        if (b == marker_byte(matched)) matched = matched + 3'd1;
        else matched = (b == marker_byte(3'd0)) ? 3'd1 : 3'd0;
        if (matched >= 3'd7) begin
          matched = 0; ph = P_HDR; idx = 0;
        end
      end
      P_HDR: begin
        case (idx)
          2: btype = b;
          3: bflags[7:0] = b;
          4: bflags[15:8] = b;
          5: bsize[7:0] = b;
          6: bsize[15:8] = b;
          default: ;
        endcase
        idx = idx + 6'd1;
        if (idx >= 6'd7) begin
          if (btype == TYPE_FILE) ph = P_FILE;
          else if (bflags[FLAG_ADD_BIT]) ph = P_ADD;
          else start_skip(bsize > 16'd7 ? 34'(bsize - 16'd7) : 34'd0);
        end
      end
      P_ADD: begin
        if (idx == 6'd7) addsz[7:0] = b;
        else addsz[15:8] = b;
        idx = idx + 6'd1;
        if (idx >= 6'd9)
          start_skip((bsize > 16'd9 ? 34'(bsize - 16'd9) : 34'd0) + {18'd0, addsz});
      end
      P_FILE: begin
        if (idx <= 10) fpk[8*(idx-7) +: 8] = b;
        else if (idx <= 14) funp[8*(idx-11) +: 8] = b;
        else if (idx == 20 || idx == 21) ftime[8*(idx-20) +: 8] = b;
        else if (idx == 22 || idx == 23) fdate[8*(idx-22) +: 8] = b;
        else if (idx == 26 || idx == 27) nlen[8*(idx-26) +: 8] = b;
        idx = idx + 6'd1;
        if (idx >= 6'd32) begin
          nleft = nlen;
          r.kind = KIND_ENTRY;
          r.pk = fpk;
          r.unp = funp;
          r.year = {5'd0, fdate[15:9]} + YEAR_BASE;
          r.month = fdate[8:5];
          r.day = fdate[4:0];
          r.hour = ftime[15:11];
          r.minute = ftime[10:5];
          r.second = {ftime[4:0], 1'b0};
          r.last = (nleft == 0);
          listing_q.push_back(r);
          if (nleft == 0) skip_file_body();
          else ph = P_NAME;
        end
      end
      P_NAME: begin
        r.kind = KIND_NAME;
        r.name_char = (b >= 8'h20 && b <= 8'h7e) ? b : 8'h3f;
        nleft = nleft - 16'd1;
        r.last = (nleft == 0);
        listing_q.push_back(r);
        if (nleft == 0) skip_file_body();
      end
      P_SKIP: begin
        skip = skip - 33'd1;
        if (skip == 0) begin
          ph = P_HDR; idx = 0;
        end
      end
      default: clear_parser();
    endcase
    if (fin) begin
      r = '{default: 0};
      r.kind = KIND_END;
      if (ph == P_SEARCH) r.status = END_NOMARK;
      else if ((ph == P_HDR && idx == 0) || ph == P_SKIP) r.status = END_CLEAN;
      else r.status = END_TRUNC;
      listing_q.push_back(r);
      clear_parser();
    end
  endtask

  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    records_seen = 0;
    clear_parser();
  end

  assign records_waiting = listing_q.size();

  always @(posedge clk) begin
    record_t e;
    if (rst_n && in_valid && !in_stall) list_byte(in_data_byte, in_stream_end);
    if (rst_n && out_valid && !out_stall) begin
      records_seen++;
      if (listing_q.size() == 0) begin
        $error("unexpected record, kind %0d", out_kind);
        fail_count++;
      end else begin
        e = listing_q.pop_front();
        cmp("kind", 32'(e.kind), 32'(out_kind));
        cmp("packed_size", e.pk, out_packed_size);
        cmp("unpacked_size", e.unp, out_unpacked_size);
        cmp("year", 32'(e.year), 32'(out_year));
        cmp("month", 32'(e.month), 32'(out_month));
        cmp("day", 32'(e.day), 32'(out_day));
        cmp("hour", 32'(e.hour), 32'(out_hour));
        cmp("minute", 32'(e.minute), 32'(out_minute));
        cmp("second", 32'(e.second), 32'(out_second));
        cmp("name_char", 32'(e.name_char), 32'(out_name_char));
        cmp("last_of_entry", 32'(e.last), 32'(out_last_of_entry));
        cmp("end_status", 32'(e.status), 32'(out_end_status));
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives archive byte streams into the header lister: directed streams for
// marker search, truncation and field extremes, then random archives built
// of file and non-file blocks, with noise and cut-off streams.
// ----------------------------------------------------------------------------
module testbench;
  import abhl_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_stream_end = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_kind;
  logic [31:0] out_packed_size, out_unpacked_size;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day, out_hour;
  logic [5:0]  out_minute, out_second;
  logic [7:0]  out_name_char;
  logic        out_last_of_entry;
  logic [1:0]  out_end_status;

  int          fail_count, records_waiting, records_seen;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          streams = 0;
  bit          quiet = 0;
  logic [7:0]  stream_q[$];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  archive_block_header_lister dut (.*);

  abhl_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[archive_block_header_lister] ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_stream_end <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends the built stream; fin on the last byte
  task automatic flush_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
    streams++;
  endtask

  task automatic put16(input logic [15:0] v);
    stream_q.push_back(v[7:0]);
    stream_q.push_back(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic put_marker();
    for (int i = 0; i < 7; i++) stream_q.push_back(marker_byte(3'(i)));
  endtask

  task automatic put_base(input logic [7:0] t, input logic [15:0] f, input logic [15:0] sz);
    put16(16'($urandom));
    stream_q.push_back(t);
    put16(f);
    put16(sz);
  endtask

  task automatic put_file(input logic [31:0] pk, input logic [31:0] unp,
                          input logic [15:0] tm, input logic [15:0] dt,
                          input int nl, input int hsize, input int body);
    put_base(TYPE_FILE, 16'($urandom), 16'(hsize));
    put32(pk);
    put32(unp);
    repeat (5) stream_q.push_back(8'($urandom));
    put16(tm);
    put16(dt);
    put16(16'($urandom));
    put16(16'(nl));
    put32($urandom);
    for (int i = 0; i < nl; i++) begin
      if ($urandom_range(0, 2) == 0) stream_q.push_back(8'($urandom));
      else stream_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end
    repeat (body) stream_q.push_back(8'($urandom));
  endtask

  task automatic put_random_file();
    int nl, hsize, extra;
    logic [31:0] pk;
    nl = $urandom_range(0, 6);
    pk = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) hsize = $urandom_range(0, 40);
    else hsize = 32 + nl + $urandom_range(0, 3);
    extra = (hsize > 32 + nl) ? hsize - 32 - nl : 0;
    put_file(pk, $urandom, 16'($urandom), 16'($urandom), nl, hsize, extra + int'(pk));
  endtask

  task automatic put_random_other();
    logic [7:0]  t;
    logic [15:0] f, sz, add;
    int body;
    do t = 8'($urandom); while (t == TYPE_FILE);
    f = 16'($urandom);
    if (f[FLAG_ADD_BIT]) begin
      sz = 16'($urandom_range(0, 20));
      add = 16'($urandom_range(0, 10));
      put_base(t, f, sz);
      put16(add);
      body = (sz > 16'd9 ? int'(sz) - 9 : 0) + int'(add);
    end else begin
      sz = 16'($urandom_range(0, 30));
      put_base(t, f, sz);
      body = sz > 16'd7 ? int'(sz) - 7 : 0;
    end
    repeat (body) stream_q.push_back(8'($urandom));
  endtask

  initial begin
    int cut;
    int nb;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // no marker at all, single-byte stream
    stream_q = '{8'h00, 8'hff, 8'h52, 8'h61};
    flush_stream();
    stream_q = '{8'h52};
    flush_stream();
    // broken marker then sliding restart on 0x52
    stream_q = '{8'h52, 8'h61, 8'h52, 8'h52, 8'h61, 8'h72, 8'h21, 8'h1a, 8'h07, 8'h00};
    put_file(0, 0, 0, 0, 0, 32, 0);
    flush_stream();
    // field extremes; stream ends inside a huge packed body
    put_marker();
    put_file(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 0, 65535, 0);
    stream_q = {stream_q, 8'h00, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'hff};
    flush_stream();
    // non-printable names, add-size block with clamp, truncated in add size
    put_marker();
    put_file(1, 7, 16'h0000, 16'h0000, 4, 3, 1);
    nb = stream_q.size();
    stream_q[nb-5] = 8'h00;
    stream_q[nb-4] = 8'h7f;
    stream_q[nb-3] = 8'h80;
    stream_q[nb-2] = 8'hff;
    put_base(8'h73, 16'h8000, 16'd0);
    put16(16'd0);
    put_base(8'h7b, 16'h8000, 16'd4);
    stream_q.push_back(8'h05);
    flush_stream();
    // truncated in the middle of a name
    put_marker();
    put_file(0, 1, 1, 1, 3, 35, 0);
    void'(stream_q.pop_back());
    flush_stream();

    while (bytes_sent < 700) begin
      if (bytes_sent > 500) quiet = 1;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
      if ($urandom_range(0, 9) != 0) put_marker();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) put_random_file();
        else put_random_other();
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, stream_q.size());
        stream_q = stream_q[0:cut-1];
      end
      flush_stream();
      if (streams == 12) begin
        in_valid <= 0;
        while (records_waiting != 0) @(negedge clk);
      end
    end
    in_valid <= 0;
    in_stream_end <= 0;

    while (records_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d archive streams; %0d records checked.",
             bytes_sent, streams, records_seen);
    if (fail_count == 0) $display("[archive_block_header_lister] OK");
    else $display("[archive_block_header_lister] ERROR");
    $finish;
  end

endmodule
